@@ hw/rtl/tcpm_pkg.sv @@
// ---------------------------------------------------------------------------
// tcpm_pkg
// shared types and constants of the two color pyrometry mean unit
// ---------------------------------------------------------------------------
package tcpm_pkg;

  localparam int unsigned LogInW  = 40;
  localparam int unsigned LogResW = 30;
  localparam int unsigned LogFrac = 24;
  localparam int unsigned DvdW    = 41;
  localparam int unsigned DvsW    = 32;
  localparam int unsigned SumW    = 37;
  localparam int unsigned CntW    = 22;

  localparam logic [CntW-1:0] MaxPixels = 22'd2097152;
  localparam logic [DvdW-1:0] K2Num     = 41'd1258104373248;

  localparam logic [1:0] RegMaskLow  = 2'd0;
  localparam logic [1:0] RegMaskHigh = 2'd1;
  localparam logic [1:0] RegFloor    = 2'd2;
  localparam logic [1:0] RegCeiling  = 2'd3;

  typedef struct packed {
    logic              start;
    logic [LogInW-1:0] value;
  } log_req_t;

  typedef struct packed {
    logic            start;
    logic [DvdW-1:0] dividend;
    logic [DvsW-1:0] divisor;
  } div_req_t;

endpackage

@@ hw/rtl/two_color_pyrometry_mean_unit.sv @@
// ---------------------------------------------------------------------------
// two_color_pyrometry_mean_unit
// frame mean of two color ratio temperature over streamed rgb pixels
// ---------------------------------------------------------------------------
// usage:
//   s_axis: one pixel word per handshake, tlast marks the frame's last pixel
//   m_axis: one result word per frame, tuser is the no_pixels flag
//   cfg: register writes, always ready, only while the block is idle
// pixel path: a skipped pixel goes straight to the end-of-frame check; a
//   qualifying pixel takes two log2 passes (shift normalize, then 24
//   squarings on one 31x31 multiplier and a done flag), then the divider,
//   which is skipped when the denominator is not positive; no new pixel is
//   taken until the current one is through
// the last pixel of a frame with qualifying pixels runs the same restoring
//   divider for the mean, then the result is loaded into the output register
// after reset a start-up pass of three log2 runs builds the constant log
//   term; no pixel is accepted meanwhile
// a stalled result holds in the output register; pixels keep being taken
//   until the next frame's result is ready to be written
// ---------------------------------------------------------------------------
module two_color_pyrometry_mean_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // red, green, blue
  input  logic        s_axis_tlast,   // last_pixel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // mean_temp, pixels_used, zero pad
  output logic        m_axis_tuser,   // no_pixels
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import tcpm_pkg::*;

  localparam logic [3:0] StCGo    = 4'd0;
  localparam logic [3:0] StCWait  = 4'd1;
  localparam logic [3:0] StIdle   = 4'd2;
  localparam logic [3:0] StP1     = 4'd3;
  localparam logic [3:0] StP2     = 4'd4;
  localparam logic [3:0] StLpWait = 4'd5;
  localparam logic [3:0] StLgWait = 4'd6;
  localparam logic [3:0] StDivGo  = 4'd7;
  localparam logic [3:0] StDivW   = 4'd8;
  localparam logic [3:0] StLast   = 4'd9;
  localparam logic [3:0] StMeanW  = 4'd10;
  localparam logic [3:0] StOut    = 4'd11;

  logic [3:0]  state_q;
  logic [1:0]  cidx_q;
  logic [7:0]  mask_low_q;
  logic [8:0]  mask_high_q;
  logic [11:0] floor_q, ceil_q;
  logic [SumW-1:0] sum_q;
  logic [CntW-1:0] cnt_q;
  logic signed [33:0] cterm_q;
  logic [7:0]  r_q, g_q;
  logic        last_q;
  logic [15:0] t1_q, t2_q, t3_q;
  logic [31:0] a_q;
  logic [LogResW-1:0] lp_q;
  logic signed [33:0] d_q;
  logic        out_valid_q;
  logic [15:0] out_mean_q;
  logic [CntW-1:0] out_cnt_q;
  logic        out_none_q;

  logic [7:0]  red, green, blue, bright;
  logic        qual;
  log_req_t    log_req;
  div_req_t    div_req;
  logic        log_done, div_done;
  logic [LogResW-1:0] log_res;
  logic [DvdW-1:0] quot;
  logic [15:0] lo16, hi16, tclamp;
  logic signed [33:0] d_new;
  logic [LogInW-1:0] cval;

  assign red   = s_axis_tdata[7:0];
  assign green = s_axis_tdata[15:8];
  assign blue  = s_axis_tdata[23:16];

  always_comb begin
    bright = red;
    if (green > bright) bright = green;
    if (blue > bright) bright = blue;
  end

  assign qual = (bright > mask_low_q) && ({1'b0, bright} < mask_high_q) &&
                (red >= 8'd8) && (red <= 8'd252) && (green >= 8'd4) &&
                (cnt_q < MaxPixels);

  assign lo16 = {floor_q, 4'd0};
  assign hi16 = {ceil_q, 4'd0};

  always_comb begin
    case (cidx_q)
      2'd0:    cval = LogInW'(10000);
      2'd1:    cval = LogInW'(615);
      default: cval = LogInW'(540);
    endcase
  end

  assign log_req.start = (state_q == StCGo) || (state_q == StP2 && a_q != 32'd1) ||
                         (state_q == StLpWait && log_done);
  assign log_req.value = (state_q == StCGo) ? cval :
                         (state_q == StP2) ? LogInW'({8'd0, a_q} * {32'd0, r_q}) :
                         {32'd0, g_q};

  assign div_req.start    = (state_q == StDivGo) ||
                            (state_q == StLast && last_q && cnt_q != '0);
  assign div_req.dividend = (state_q == StDivGo) ? K2Num + DvdW'(d_q[33:1]) :
                            {4'd0, sum_q} + DvdW'(cnt_q[CntW-1:1]);
  assign div_req.divisor  = (state_q == StDivGo) ? d_q[31:0] : {10'd0, cnt_q};

  assign d_new = $signed({4'd0, lp_q}) - $signed({3'd0, log_res, 1'b0}) -
                 $signed({4'd0, log_res}) + cterm_q;

  always_comb begin
    if (quot > DvdW'(hi16)) tclamp = hi16;
    else if (quot < DvdW'(lo16)) tclamp = lo16;
    else tclamp = quot[15:0];
  end

  tcpm_log2 u_log (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (log_req),
    .done_o (log_done),
    .res_o  (log_res)
  );

  tcpm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StCGo;
      cidx_q      <= 2'd0;
      cterm_q     <= '0;
      mask_low_q  <= 8'd0;
      mask_high_q <= 9'd256;
      floor_q     <= 12'd1000;
      ceil_q      <= 12'd3000;
      sum_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          RegMaskLow:  mask_low_q  <= cfg_data_i[7:0];
          RegMaskHigh: mask_high_q <= cfg_data_i[8:0];
          RegFloor:    floor_q     <= cfg_data_i[11:0];
          RegCeiling:  ceil_q      <= cfg_data_i[11:0];
          default: ;
        endcase
      end
      if (out_valid_q && m_axis_tready && state_q != StOut) out_valid_q <= 1'b0;
      case (state_q)
        StCGo: state_q <= StCWait;
        StCWait: begin
          if (log_done) begin
            case (cidx_q)
              2'd0:    cterm_q <= cterm_q - $signed({4'd0, log_res});
              2'd1:    cterm_q <= cterm_q + $signed({1'b0, log_res, 3'd0})
                                  - $signed({3'd0, log_res, 1'b0});
              default: cterm_q <= cterm_q - $signed({1'b0, log_res, 3'd0})
                                  + $signed({3'd0, log_res, 1'b0});
            endcase
            cidx_q  <= cidx_q + 2'd1;
            state_q <= (cidx_q == 2'd2) ? StIdle : StCGo;
          end
        end
        StIdle: begin
          if (s_axis_tvalid) begin
            last_q  <= s_axis_tlast;
            r_q     <= red;
            g_q     <= green;
            state_q <= qual ? StP1 : StLast;
          end
        end
        StP1: begin
          t1_q    <= {8'd0, r_q} * {8'd0, r_q};
          t2_q    <= {8'd0, r_q} * {8'd0, g_q};
          t3_q    <= {8'd0, g_q} * {8'd0, g_q};
          a_q     <= 32'd1;
          state_q <= StP2;
        end
        StP2: begin
          if (a_q == 32'd1) begin
            a_q <= 32'd3653 * {16'd0, t1_q} - 32'd16690 * {16'd0, t2_q} +
                   32'd33920 * {16'd0, t3_q};
          end else begin
            a_q     <= '0;
            state_q <= StLpWait;
          end
        end
        StLpWait: begin
          if (log_done) begin
            lp_q    <= log_res;
            state_q <= StLgWait;
          end
        end
        StLgWait: begin
          if (log_done) begin
            d_q <= d_new;
            if (d_new <= 0) begin
              sum_q   <= sum_q + SumW'(lo16);
              cnt_q   <= cnt_q + CntW'(1);
              state_q <= StLast;
            end else begin
              state_q <= StDivGo;
            end
          end
        end
        StDivGo: state_q <= StDivW;
        StDivW: begin
          if (div_done) begin
            sum_q   <= sum_q + SumW'(tclamp);
            cnt_q   <= cnt_q + CntW'(1);
            state_q <= StLast;
          end
        end
        StLast: begin
          if (!last_q) state_q <= StIdle;
          else if (cnt_q == '0) state_q <= StOut;
          else state_q <= StMeanW;
        end
        StMeanW: if (div_done) state_q <= StOut;
        StOut: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            out_none_q  <= (cnt_q == '0);
            out_cnt_q   <= cnt_q;
            out_mean_q  <= (cnt_q == '0) ? 16'd0 : quot[15:0];
            sum_q       <= '0;
            cnt_q       <= '0;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign s_axis_tready = (state_q == StIdle);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'd0, out_cnt_q, out_mean_q};
  assign m_axis_tuser  = out_none_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MaxPixels) else $error("pixel count past limit");
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == StOut)) else $error("result not from out");
  a_idle_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !div_done && !log_done) else $error("unit done while idle");

endmodule

@@ hw/rtl/tcpm_log2.sv @@
// ---------------------------------------------------------------------------
// tcpm_log2
// iterative log2 in q24: bit-serial normalize, then one squaring per cycle
// ---------------------------------------------------------------------------
module tcpm_log2 (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tcpm_pkg::log_req_t            req_i,
  output logic                          done_o,
  output logic [tcpm_pkg::LogResW-1:0]  res_o
);
  import tcpm_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StNorm = 2'd1;
  localparam logic [1:0] StSq   = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [LogInW-1:0]  norm_q, norm_d;
  logic [5:0]         shift_q, shift_d;
  logic [4:0]         iter_q, iter_d;
  logic [30:0]        m_q, m_d;
  logic [LogResW-1:0] res_q, res_d;
  logic               done_q, done_d;
  logic [61:0]        sq;
  logic [31:0]        m2;

  assign sq = {31'd0, m_q} * {31'd0, m_q};
  assign m2 = sq[61:30];

  always_comb begin
    state_d = state_q;
    norm_d  = norm_q;
    shift_d = shift_q;
    iter_d  = iter_q;
    m_d     = m_q;
    res_d   = res_q;
    done_d  = 1'b0;
    case (state_q)
      StIdle: begin
        if (req_i.start) begin
          norm_d  = req_i.value;
          shift_d = 6'd0;
          state_d = StNorm;
        end
      end
      StNorm: begin
        if (norm_q[LogInW-1]) begin
          m_d     = norm_q[LogInW-1:9];
          res_d   = LogResW'(6'd39 - shift_q);
          iter_d  = 5'd0;
          state_d = StSq;
        end else begin
          norm_d  = {norm_q[LogInW-2:0], 1'b0};
          shift_d = shift_q + 6'd1;
        end
      end
      StSq: begin
        if (m2[31]) begin
          res_d = {res_q[LogResW-2:0], 1'b1};
          m_d   = m2[31:1];
        end else begin
          res_d = {res_q[LogResW-2:0], 1'b0};
          m_d   = m2[30:0];
        end
        iter_d = iter_q + 5'd1;
        if (iter_q == 5'(LogFrac - 1)) begin
          done_d  = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    norm_q  <= norm_d;
    shift_q <= shift_d;
    iter_q  <= iter_d;
    m_q     <= m_d;
    res_q   <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

@@ hw/rtl/tcpm_div.sv @@
// ---------------------------------------------------------------------------
// tcpm_div
// restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
module tcpm_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tcpm_pkg::div_req_t          req_i,
  output logic                        done_o,
  output logic [tcpm_pkg::DvdW-1:0]   quot_o
);
  import tcpm_pkg::*;

  logic            busy_q, done_q;
  logic [5:0]      cnt_q;
  logic [DvdW-1:0] dvd_q;
  logic [DvsW-1:0] rem_q;
  logic [DvsW-1:0] dvs_q;
  logic [DvsW:0]   trial;

  assign trial = {rem_q, dvd_q[DvdW-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (!busy_q && req_i.start) begin
        busy_q <= 1'b1;
      end else if (busy_q && cnt_q == 6'(DvdW - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!busy_q) begin
      if (req_i.start) begin
        dvd_q <= req_i.dividend;
        dvs_q <= req_i.divisor;
        rem_q <= '0;
        cnt_q <= 6'd0;
      end
    end else begin
      cnt_q <= cnt_q + 6'd1;
      if (trial >= {1'b0, dvs_q}) begin
        rem_q <= DvsW'(trial - {1'b0, dvs_q});
        dvd_q <= {dvd_q[DvdW-2:0], 1'b1};
      end else begin
        rem_q <= trial[DvsW-1:0];
        dvd_q <= {dvd_q[DvdW-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;

endmodule

@@ tb/sv/two_color_pyrometry_mean_checker.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// two_color_pyrometry_mean_checker
// watches the pixel, result and register channels of the pyrometry mean
// unit, predicts each frame's mean temperature and compares it word by word
// ---------------------------------------------------------------------------
module two_color_pyrometry_mean_checker
  import tcpm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,
  input  logic        m_axis_tuser,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          results_o,
  output int          no_pixel_results_o
);

  typedef struct {
    logic [15:0]     mean_temp;
    logic [CntW-1:0] pixels_used;
    logic            no_pixels;
  } frame_mean_t;

  frame_mean_t     mean_q[$];
  logic [7:0]      mask_low;
  logic [8:0]      mask_high;
  logic [11:0]     temp_floor;
  logic [11:0]     temp_ceiling;
  logic [SumW-1:0] temp_sum;
  logic [CntW-1:0] pixel_count;
  longint          log_const;

  function automatic longint log2_q24(longint unsigned v);
    int unsigned    e;
    longint unsigned m;
    longint         acc;
    if (v == 0) return 0;
    e = 0;
    while (e < 63 && (v >> (e + 1)) != 0) e++;
    m = (e <= 30) ? (v << (30 - e)) : (v >> (e - 30));
    acc = e;
    for (int i = 0; i < LogFrac; i++) begin
      m = (m * m) >> 30;
      acc = acc * 2;
      if ((m >> 31) != 0) begin
        acc += 1;
        m >>= 1;
      end
    end
    return acc;
  endfunction

  function automatic longint unsigned ratio_temp(longint unsigned r, longint unsigned g);
    longint unsigned p;
    longint          d;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned t;
    p  = 3653 * r * r * r + 33920 * r * g * g - 16690 * r * r * g;
    d  = log2_q24(p) - 3 * log2_q24(g) - log_const;
    lo = longint'(temp_floor) * 16;
    hi = longint'(temp_ceiling) * 16;
    if (d <= 0) return lo;
    t = (longint'(K2Num) + longint'(d) / 2) / longint'(d);
    if (t > hi) return hi;
    if (t < lo) return lo;
    return t;
  endfunction

  initial begin
    log_const = log2_q24(10000) - 6 * (log2_q24(615) - log2_q24(540));
  end

  assign pending_o = mean_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    logic [7:0]   r;
    logic [7:0]   g;
    logic [7:0]   b;
    logic [7:0]   bright;
    frame_mean_t  exp_w;
    frame_mean_t  got_w;
    if (!rst_ni) begin
      mask_low     <= 8'd0;
      mask_high    <= 9'd256;
      temp_floor   <= 12'd1000;
      temp_ceiling <= 12'd3000;
      temp_sum     <= '0;
      pixel_count  <= '0;
      fail_count_o <= 0;
      results_o    <= 0;
      no_pixel_results_o <= 0;
      mean_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          RegMaskLow:  mask_low     <= cfg_data_i[7:0];
          RegMaskHigh: mask_high    <= cfg_data_i[8:0];
          RegFloor:    temp_floor   <= cfg_data_i[11:0];
          RegCeiling:  temp_ceiling <= cfg_data_i[11:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        logic [SumW-1:0] sum_n;
        logic [CntW-1:0] cnt_n;
        r = s_axis_tdata[7:0];
        g = s_axis_tdata[15:8];
        b = s_axis_tdata[23:16];
        bright = r;
        if (g > bright) bright = g;
        if (b > bright) bright = b;
        sum_n = temp_sum;
        cnt_n = pixel_count;
        if ({1'b0, bright} > {1'b0, mask_low} && {1'b0, bright} < mask_high &&
            r >= 8 && r <= 252 && g >= 4 && cnt_n < MaxPixels) begin
          sum_n += ratio_temp(r, g);
          cnt_n += 1;
        end
        if (s_axis_tlast) begin
          if (cnt_n == 0) begin
            exp_w = '{16'd0, '0, 1'b1};
          end else begin
            exp_w.mean_temp   = 16'((sum_n + cnt_n / 2) / cnt_n);
            exp_w.pixels_used = cnt_n;
            exp_w.no_pixels   = 1'b0;
          end
          mean_q.push_back(exp_w);
          sum_n = '0;
          cnt_n = '0;
        end
        temp_sum    <= sum_n;
        pixel_count <= cnt_n;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_w = '{m_axis_tdata[15:0], m_axis_tdata[37:16], m_axis_tuser};
        results_o <= results_o + 1;
        if (m_axis_tuser) no_pixel_results_o <= no_pixel_results_o + 1;
        if (mean_q.size() == 0) begin
          if (fail_count_o < 10)
            $display("%0t unexpected word mean=%0d used=%0d none=%0b", $realtime,
                     got_w.mean_temp, got_w.pixels_used, got_w.no_pixels);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_w = mean_q.pop_front();
          if (got_w.mean_temp !== exp_w.mean_temp ||
              got_w.pixels_used !== exp_w.pixels_used ||
              got_w.no_pixels !== exp_w.no_pixels || m_axis_tdata[39:38] !== 2'b00) begin
            if (fail_count_o < 10)
              $display("%0t mismatch exp mean=%0d used=%0d none=%0b got mean=%0d used=%0d none=%0b",
                       $realtime, exp_w.mean_temp, exp_w.pixels_used, exp_w.no_pixels,
                       got_w.mean_temp, got_w.pixels_used, got_w.no_pixels);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

@@ tb/sv/two_color_pyrometry_mean_unit_tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// two_color_pyrometry_mean_unit_tb
// drives pixel frames and register settings into the pyrometry mean unit
// with random gaps and back pressure; the checker predicts and compares
// ---------------------------------------------------------------------------
module two_color_pyrometry_mean_unit_tb;
  import tcpm_pkg::*;

  localparam int CycleLimit = 3000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = RegMaskLow;
  logic [15:0] cfg_data = '0;
  int          fail_count;
  int          pending;
  int          results;
  int          no_pixel_results;
  int          pixels_sent = 0;
  int          cycles = 0;

  two_color_pyrometry_mean_unit u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready), .s_axis_tdata(s_tdata),
    .s_axis_tlast(s_tlast),
    .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready), .m_axis_tdata(m_tdata),
    .m_axis_tuser(m_tuser),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data)
  );

  two_color_pyrometry_mean_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready), .s_axis_tdata(s_tdata),
    .s_axis_tlast(s_tlast),
    .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready), .m_axis_tdata(m_tdata),
    .m_axis_tuser(m_tuser),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending), .results_o(results),
    .no_pixel_results_o(no_pixel_results)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int gap_len();
    int sel;
    sel = $urandom_range(99);
    if (sel < 65) return 0;
    if (sel < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  // receiver: random stalls plus two long hold-offs
  initial begin
    int hold;
    int rx_cycles;
    rx_cycles = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      rx_cycles++;
      if (rx_cycles == 30000 || rx_cycles == 160000) hold = 8000;
      else if (hold == 0 && $urandom_range(99) < 20) hold = gap_len();
      if (hold > 0) begin
        m_tready <= 1'b0;
        hold--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CycleLimit) begin
        $display("timeout after %0d cycles", cycles);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic last);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= {b, g, r};
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    pixels_sent++;
    gap = gap_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (300) @(posedge clk);
  endtask

  task automatic random_frames(int n);
    int left;
    int len;
    logic [7:0] r;
    logic [7:0] g;
    left = n;
    while (left > 0) begin
      len = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 14);
      if (len > left) len = left;
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(99) < 80) begin
          r = 8'($urandom_range(8, 252));
          g = 8'($urandom_range(4, 255));
        end else begin
          r = 8'($urandom_range(255));
          g = 8'($urandom_range(255));
        end
        send_pixel(r, g, 8'($urandom_range(255)), i == len - 1);
      end
      left -= len;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: channel extremes, mask edges, negative log term
    send_pixel(8'd8, 8'd4, 8'd0, 1'b0);
    send_pixel(8'd252, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd7, 8'd100, 8'd0, 1'b0);
    send_pixel(8'd253, 8'd100, 8'd0, 1'b0);
    send_pixel(8'd100, 8'd3, 8'd0, 1'b0);
    send_pixel(8'd100, 8'd0, 8'd0, 1'b1);
    send_pixel(8'd8, 8'd255, 8'd0, 1'b1);
    send_pixel(8'd200, 8'd200, 8'd0, 1'b1);
    send_pixel(8'd252, 8'd4, 8'd0, 1'b1);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
    send_pixel(8'd150, 8'd120, 8'd30, 1'b0);
    send_pixel(8'd60, 8'd90, 8'd10, 1'b1);
    drain();

    write_reg(RegMaskLow, 16'd100);
    write_reg(RegMaskHigh, 16'd200);
    send_pixel(8'd100, 8'd90, 8'd0, 1'b0);
    send_pixel(8'd101, 8'd90, 8'd0, 1'b0);
    send_pixel(8'd150, 8'd90, 8'd200, 1'b0);
    send_pixel(8'd199, 8'd90, 8'd0, 1'b1);
    send_pixel(8'd50, 8'd90, 8'd100, 1'b1);
    drain();
    random_frames(200);
    drain();

    // floor above ceiling, and wide writes keep only the low bits
    write_reg(RegMaskLow, 16'hFF00);
    write_reg(RegMaskHigh, 16'hFE00 | 16'd256);
    write_reg(RegFloor, 16'd4095);
    write_reg(RegCeiling, 16'hF000);
    send_pixel(8'd100, 8'd90, 8'd0, 1'b1);
    random_frames(200);
    drain();

    write_reg(RegFloor, 16'd0);
    write_reg(RegCeiling, 16'd4095);
    random_frames(250);
    drain();

    // nothing can qualify
    write_reg(RegMaskLow, 16'd255);
    write_reg(RegMaskHigh, 16'd0);
    random_frames(60);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      write_reg(RegMaskLow, 16'($urandom_range(16'hFFFF)) & 16'h803F);
      write_reg(RegMaskHigh, 16'(($urandom_range(16'hFFFF) & 32'hFE00) |
                                 $urandom_range(180, 256)));
      write_reg(RegFloor, 16'($urandom_range(16'hFFFF)) & 16'hF7FF);
      write_reg(RegCeiling, 16'($urandom_range(16'hFFFF)) | 16'h0800);
      random_frames(220);
      drain();
    end

    $display("pixels sent %0d, frame results %0d of which %0d without qualifying pixels",
             pixels_sent, results, no_pixel_results);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("failures %0d, results still expected %0d", fail_count, pending);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/tcpm_pkg.sv
hw/rtl/tcpm_log2.sv
hw/rtl/tcpm_div.sv
hw/rtl/two_color_pyrometry_mean_unit.sv
tb/sv/two_color_pyrometry_mean_checker.sv
tb/sv/two_color_pyrometry_mean_unit_tb.sv
